>>> sv/rc5fpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC5 frame pulse encoder package
// Shared widths, reset values, register indexes and the configuration struct.
// ----------------------------------------------------------------------------
package rc5fpe_pkg;

  localparam int unsigned FrameBits   = 14;
  localparam int unsigned CarrierW    = 8;
  localparam int unsigned HalfW       = 16;
  localparam int unsigned ValueW      = HalfW + 1;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned BitCntW     = $clog2(FrameBits);

  localparam logic [CarrierW-1:0] ResetCarrier = CarrierW'(36);
  localparam logic [HalfW-1:0]    ResetHalf    = HalfW'(32);

  typedef enum logic [0:0] {
    RegCarrier = 1'b0,
    RegHalf    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CarrierW-1:0] carrier_khz;
    logic [HalfW-1:0]    half_bit_units;
  } cfg_t;

endpackage

>>> sv/rc5fpe_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC5 encoder configuration registers
// Holds the carrier word and the half-bit duration written over the plain
// write port.
// ----------------------------------------------------------------------------
module rc5fpe_cfg import rc5fpe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.carrier_khz    <= ResetCarrier;
      cfg_q.half_bit_units <= ResetHalf;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegCarrier: cfg_q.carrier_khz    <= cfg_data_i[CarrierW-1:0];
        RegHalf:    cfg_q.half_bit_units <= cfg_data_i[HalfW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/rc5_frame_pulse_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC5 frame pulse encoder
// Builds the 14-bit RC5 frame and emits the carrier word followed by the
// Manchester pulse durations, one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o toggle_i, address_i, command_i
// out      output     out_valid_o/out_stall_i value_o, is_carrier_o, last_o
// cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// One item gives 16 to 28 results, one per cycle while the output is not
// stalled; the frame shift register moves one bit per bit step, and an item
// keeps the input stalled until its closing result is registered.
// A new item is taken once the closing result sits in the output register.
// Reset restores carrier 36 and half bit 32 and empties the output register.
// An output stall freezes the sequencer and the output register, except that
// a new item can still be taken while the closing result waits.
// ----------------------------------------------------------------------------
module rc5_frame_pulse_encoder import rc5fpe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                toggle_i,
  input  logic [4:0]          address_i,
  input  logic [5:0]          command_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ValueW-1:0]   value_o,
  output logic                is_carrier_o,
  output logic                last_o
);

  typedef enum logic [1:0] {
    StIdle,
    StCarrier,
    StPulse,
    StClose
  } state_e;

  cfg_t                 cfg;
  state_e               state_q;
  logic [FrameBits-1:0] frame_q;
  logic [BitCntW-1:0]   cnt_q;
  logic                 second_q;
  logic                 out_valid_q;
  logic [ValueW-1:0]    value_q;
  logic                 is_carrier_q;
  logic                 last_q;
  logic                 in_accept;
  logic                 advance;
  logic                 bits_differ;

  rc5fpe_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign advance     = !out_valid_q || !out_stall_i;
  assign bits_differ = frame_q[FrameBits-1] ^ frame_q[FrameBits-2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      frame_q      <= '0;
      cnt_q        <= '0;
      second_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      value_q      <= '0;
      is_carrier_q <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      if (advance && state_q == StIdle) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_accept) begin
            frame_q  <= {2'b11, toggle_i, address_i, command_i};
            cnt_q    <= BitCntW'(FrameBits - 1);
            second_q <= 1'b0;
            state_q  <= StCarrier;
          end
        end
        StCarrier: begin
          if (advance) begin
            out_valid_q  <= 1'b1;
            value_q      <= ValueW'(cfg.carrier_khz);
            is_carrier_q <= 1'b1;
            last_q       <= 1'b0;
            state_q      <= StPulse;
          end
        end
        StPulse: begin
          if (advance) begin
            out_valid_q  <= 1'b1;
            is_carrier_q <= 1'b0;
            last_q       <= 1'b0;
            if (bits_differ) begin
              value_q <= {cfg.half_bit_units, 1'b0};
            end else begin
              value_q <= {1'b0, cfg.half_bit_units};
            end
            if (bits_differ || second_q) begin
              second_q <= 1'b0;
              frame_q  <= {frame_q[FrameBits-2:0], 1'b0};
              cnt_q    <= cnt_q - BitCntW'(1);
              if (cnt_q == BitCntW'(1)) begin
                state_q <= StClose;
              end
            end else begin
              second_q <= 1'b1;
            end
          end
        end
        StClose: begin
          if (advance) begin
            out_valid_q  <= 1'b1;
            value_q      <= {1'b0, cfg.half_bit_units};
            is_carrier_q <= 1'b0;
            last_q       <= 1'b1;
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign is_carrier_o = is_carrier_q;
  assign last_o       = last_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == StCarrier)
    else $error("Accepted item did not start with the carrier result.");

  a_close_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClose && advance) |=> (state_q == StIdle && out_valid_q && last_q))
    else $error("Closing result not presented as last.");

  a_pulse_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StPulse |-> cnt_q != '0)
    else $error("Bit counter empty during pulse steps.");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(last_q && is_carrier_q))
    else $error("Result flagged both carrier and last.");

endmodule
